@@ src/stit_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stit_pkg: shared types and constants of the sorted timestamp index table
// Record layout, status codes, read-address selects and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package stit_pkg;

   localparam int STIT_CAPACITY = 256;
   localparam int DATA_W        = 64;
   localparam int STAT_W        = 3;
   localparam int HELD_W        = 9;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   localparam logic [1:0] RD_MID   = 2'd0;
   localparam logic [1:0] RD_LO    = 2'd1;
   localparam logic [1:0] RD_LOM1  = 2'd2;
   localparam logic [1:0] RD_SHIFT = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] position;
      logic [DATA_W-1:0] frames;
   } rec_type;

   typedef struct packed {
      logic              load_req;
      logic              rd_en;
      logic [1:0]        rd_sel;
      logic              step;
      logic              shift_init;
      logic              shift_step;
      logic              insert;
      logic              res_load;
      logic [STAT_W-1:0] res_status;
      logic              res_take_rd;
      logic              emit;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic is_find;
      logic cnt_zero;
      logic hit;
      logic full;
      logic lo_zero;
      logic shift_done;
      logic out_free;
   } sts_type;

endpackage

@@ src/stit_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stit_dp: datapath of the sorted timestamp index table
// Record memory, search bounds, shift pointer, entry count, result hold
// register and the output register of the result channel.
// ----------------------------------------------------------------------------
module stit_dp
   import stit_pkg::*;
#(
   parameter int CAPACITY = STIT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_func,
   input  logic [DATA_W-1:0] req_timestamp,
   input  logic [DATA_W-1:0] req_file_position,
   input  logic [DATA_W-1:0] req_frame_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_found_timestamp,
   output logic [DATA_W-1:0] rsp_found_position,
   output logic [DATA_W-1:0] rsp_found_frames,
   output logic [HELD_W-1:0] rsp_entries_held,
   input  cmd_type           cmd,
   output sts_type           sts
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   rec_type rec_mem [CAPACITY];

   logic              func_ff, func_in;
   rec_type           req_ff, req_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     wa_ff, wa_in;
   rec_type           rd_data_ff;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   rec_type           res_rec_ff, res_rec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   rec_type           rsp_rec_ff, rsp_rec_in;
   logic [HELD_W-1:0] rsp_held_ff, rsp_held_in;

   logic [CW-1:0]     span;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     lo_m1;
   logic [CW-1:0]     ptr_m1;
   logic [IW-1:0]     rd_addr;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   rec_type           mem_wd;

   assign span   = hi_ff - lo_ff;
   assign mid    = lo_ff + (span >> 1);
   assign lo_m1  = lo_ff - ONE;
   assign ptr_m1 = ptr_ff - ONE;

   always_comb begin
      case (cmd.rd_sel)
         RD_MID:   rd_addr = mid[IW-1:0];
         RD_LO:    rd_addr = lo_ff[IW-1:0];
         RD_LOM1:  rd_addr = lo_m1[IW-1:0];
         RD_SHIFT: rd_addr = ptr_m1[IW-1:0];
         default:  rd_addr = '0;
      endcase
   end

   assign mem_we = pend_ff | cmd.insert;
   assign mem_wa = cmd.insert ? lo_ff[IW-1:0] : wa_ff;
   assign mem_wd = cmd.insert ? req_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= rec_mem[rd_addr];
      end
   end

   always_comb begin
      sts.search_done = !(lo_ff < hi_ff);
      sts.is_find     = func_ff;
      sts.cnt_zero    = (cnt_ff == '0);
      sts.hit         = (lo_ff < cnt_ff) && (rd_data_ff.stamp == req_ff.stamp);
      sts.full        = (cnt_ff == CAP_CNT);
      sts.lo_zero     = (lo_ff == '0);
      sts.shift_done  = (ptr_ff == lo_ff);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      func_in       = func_ff;
      req_in        = req_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      wa_in         = wa_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_held_in   = rsp_held_ff;
      if (cmd.load_req) begin
         func_in         = req_func;
         req_in.stamp    = req_timestamp;
         req_in.position = req_file_position;
         req_in.frames   = req_frame_count;
         lo_in           = '0;
         hi_in           = cnt_ff;
      end
      if (cmd.step) begin
         if (rd_data_ff.stamp < req_ff.stamp) begin
            lo_in = mid + ONE;
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.shift_init) begin
         ptr_in = cnt_ff;
      end
      if (cmd.shift_step) begin
         ptr_in  = ptr_m1;
         pend_in = 1'b1;
         wa_in   = ptr_ff[IW-1:0];
      end
      if (cmd.insert) begin
         cnt_in = cnt_ff + ONE;
      end
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_rec_in    = cmd.res_take_rd ? rd_data_ff : '0;
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_rec_in    = res_rec_ff;
         rsp_held_in   = HELD_W'(cnt_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      req_ff        <= req_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ptr_ff        <= ptr_in;
      wa_ff         <= wa_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_held_ff   <= rsp_held_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found_timestamp = rsp_rec_ff.stamp;
   assign rsp_found_position  = rsp_rec_ff.position;
   assign rsp_found_frames    = rsp_rec_ff.frames;
   assign rsp_entries_held    = rsp_held_ff;

endmodule

@@ src/stit_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stit_ctrl: controller of the sorted timestamp index table
// Sequences the binary search, duplicate and full checks, the shift of
// stored records for an insert, the find pick and the result hand-off.
// ----------------------------------------------------------------------------
module stit_ctrl
   import stit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_SHIFT  = 3'd5;
   localparam logic [2:0] S_INSERT = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.rd_en = 1'b1;
            if (!sts.search_done) begin
               cmd.rd_sel = RD_MID;
               state_in   = S_CMP;
            end else begin
               cmd.rd_sel = RD_LO;
               state_in   = S_CHECK;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            if (sts.is_find) begin
               if (sts.cnt_zero) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_EMPTY;
                  state_in       = S_EMIT;
               end else if (sts.hit || sts.lo_zero) begin
                  cmd.res_load    = 1'b1;
                  cmd.res_status  = ST_FOUND;
                  cmd.res_take_rd = 1'b1;
                  state_in        = S_EMIT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LOM1;
                  state_in   = S_FETCH;
               end
            end else begin
               if (sts.hit) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_DUPLICATE;
                  state_in       = S_EMIT;
               end else if (sts.full) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_FULL;
                  state_in       = S_EMIT;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end
            end
         end
         S_FETCH: begin
            cmd.res_load    = 1'b1;
            cmd.res_status  = ST_FOUND;
            cmd.res_take_rd = 1'b1;
            state_in        = S_EMIT;
         end
         S_SHIFT: begin
            if (!sts.shift_done) begin
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_SHIFT;
               cmd.shift_step = 1'b1;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.insert     = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_INSERTED;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/sorted_timestamp_index_table.sv @@
`timescale 1ns / 1ps
// Find: a binary search of S steps (at most ceil(log2(CAPACITY+1))), then the pick;
// record: the same search, then one stored entry shifted per cycle, then the insert.
// Flow: one beat in flight at a time; a new request is taken only once the result
// of the last one is in the output register. The record memory reads and writes in one cycle.
// Reset: entry count and control clear at once; record memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_timestamp_index_table: sorted seek index with insert and floor search
// Holds records sorted by timestamp; inserts new records in order and returns
// the record with the greatest timestamp not above a query, else the lowest one.
// ----------------------------------------------------------------------------
module sorted_timestamp_index_table
   import stit_pkg::*;
#(
   parameter int CAPACITY = STIT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [DATA_W-1:0] req_timestamp,
   input  logic [DATA_W-1:0] req_file_position,
   input  logic [DATA_W-1:0] req_frame_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_found_timestamp,
   output logic [DATA_W-1:0] rsp_found_position,
   output logic [DATA_W-1:0] rsp_found_frames,
   output logic [HELD_W-1:0] rsp_entries_held
);

   cmd_type cmd;
   sts_type sts;

   stit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stit_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_func            (req_func),
      .req_timestamp       (req_timestamp),
      .req_file_position   (req_file_position),
      .req_frame_count     (req_frame_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_found_timestamp (rsp_found_timestamp),
      .rsp_found_position  (rsp_found_position),
      .rsp_found_frames    (rsp_found_frames),
      .rsp_entries_held    (rsp_entries_held),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

@@ sim/stit_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stit_tb_pkg: request codes for the index table testbench
// Function codes of a request beat, shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package stit_tb_pkg;

   localparam logic FN_RECORD = 1'b0;
   localparam logic FN_FIND   = 1'b1;

endpackage

@@ sim/stit_index_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stit_index_checker: scoreboard for the sorted timestamp index table
// Watches the request and response channels, keeps its own sorted copy of
// the index, predicts the response of every accepted request and compares
// each response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stit_index_checker
   import stit_pkg::*;
   import stit_tb_pkg::*;
#(
   parameter int CAPACITY = STIT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_func,
   input  logic [DATA_W-1:0] req_timestamp,
   input  logic [DATA_W-1:0] req_file_position,
   input  logic [DATA_W-1:0] req_frame_count,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [DATA_W-1:0] rsp_found_timestamp,
   input  logic [DATA_W-1:0] rsp_found_position,
   input  logic [DATA_W-1:0] rsp_found_frames,
   input  logic [HELD_W-1:0] rsp_entries_held,
   input  logic              end_of_test,
   output int                fail_count,
   output int                outstanding
);

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] position;
      logic [DATA_W-1:0] frames;
      logic [HELD_W-1:0] held;
   } lookup_result_type;

   logic [DATA_W-1:0] stamp_tab    [CAPACITY];
   logic [DATA_W-1:0] position_tab [CAPACITY];
   logic [DATA_W-1:0] frames_tab   [CAPACITY];
   int                held_count;
   int                peak_held;
   int                results_seen;
   int                status_tally [0:ST_EMPTY];
   logic              leftover_checked;
   lookup_result_type expected_q [$];

   initial begin
      fail_count       = 0;
      outstanding      = 0;
      held_count       = 0;
      peak_held        = 0;
      results_seen     = 0;
      leftover_checked = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("[%0t] result %0d: %s", $time, results_seen, what);
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   task automatic apply_request(input logic func, input logic [DATA_W-1:0] stamp,
                                input logic [DATA_W-1:0] pos,
                                input logic [DATA_W-1:0] frames,
                                output lookup_result_type r);
      int   slot;
      int   pick;
      int   i;
      logic hit;
      r    = '0;
      slot = 0;
      while (slot < held_count && stamp_tab[slot] < stamp) slot++;
      hit = 1'b0;
      if (slot < held_count) hit = (stamp_tab[slot] == stamp);
      if (func == FN_RECORD) begin
         if (hit) begin
            r.status = ST_DUPLICATE;
         end else if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (i = held_count; i > slot; i--) begin
               stamp_tab[i]    = stamp_tab[i-1];
               position_tab[i] = position_tab[i-1];
               frames_tab[i]   = frames_tab[i-1];
            end
            stamp_tab[slot]    = stamp;
            position_tab[slot] = pos;
            frames_tab[slot]   = frames;
            held_count++;
            r.status = ST_INSERTED;
         end
      end else if (held_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         if (hit)
            pick = slot;
         else if (slot == 0)
            pick = 0;
         else
            pick = slot - 1;
         r.status   = ST_FOUND;
         r.stamp    = stamp_tab[pick];
         r.position = position_tab[pick];
         r.frames   = frames_tab[pick];
      end
      r.held = held_count[HELD_W-1:0];
   endtask

   always @(posedge clock) begin : monitor
      lookup_result_type want;
      if (reset) begin
         expected_q.delete();
         held_count = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("response beat with none expected, status %0d",
                                         rsp_status));
            end else begin
               want = expected_q.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("found_timestamp", rsp_found_timestamp, want.stamp);
               check_field("found_position", rsp_found_position, want.position);
               check_field("found_frames", rsp_found_frames, want.frames);
               check_field("entries_held", rsp_entries_held, want.held);
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_func, req_timestamp, req_file_position, req_frame_count,
                          want);
            expected_q.push_back(want);
            status_tally[want.status]++;
            if (held_count > peak_held) peak_held = held_count;
         end
         if (end_of_test && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_q.size() != 0)
               report_mismatch($sformatf("%0d expected responses never arrived",
                                         expected_q.size()));
         end
         outstanding <= expected_q.size();
      end
   end

endmodule

@@ sim/tb_sorted_timestamp_index_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timestamp_index_table: testbench for the sorted timestamp index
// Drives directed record and find beats (empty table, edge timestamps,
// duplicates, queries below, between and above the stored records), then
// random bursts that fill the table to capacity and keep hitting it when
// full, with random sender gaps, a varying receiver stall pattern and one
// long receiver hold-off. The checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_sorted_timestamp_index_table;
   import stit_pkg::*;
   import stit_tb_pkg::*;

   localparam int RANDOM_ITEMS    = 1330;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 300;
   localparam int CYCLE_LIMIT     = 2_000_000;

   localparam logic [DATA_W-1:0] ALL_ONES     = '1;
   localparam logic [DATA_W-1:0] CLUSTER_BASE = 64'h0000_0100_0000_0000;

   typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_DUTY, RX_COIN} rx_style_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic              req_func          = FN_RECORD;
   logic [DATA_W-1:0] req_timestamp     = '0;
   logic [DATA_W-1:0] req_file_position = '0;
   logic [DATA_W-1:0] req_frame_count   = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_found_timestamp;
   logic [DATA_W-1:0] rsp_found_position;
   logic [DATA_W-1:0] rsp_found_frames;
   logic [HELD_W-1:0] rsp_entries_held;

   logic              end_of_test       = 1'b0;
   logic              hold_off          = 1'b0;
   int unsigned       cycle_count       = 0;
   int unsigned       beats_sent        = 0;
   int unsigned       records_sent      = 0;
   int                fail_count;
   int                outstanding;
   logic [DATA_W-1:0] stamp_pool [$];

   sorted_timestamp_index_table u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_timestamp       (req_timestamp),
      .req_file_position   (req_file_position),
      .req_frame_count     (req_frame_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_found_timestamp (rsp_found_timestamp),
      .rsp_found_position  (rsp_found_position),
      .rsp_found_frames    (rsp_found_frames),
      .rsp_entries_held    (rsp_entries_held)
   );

   stit_index_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_timestamp       (req_timestamp),
      .req_file_position   (req_file_position),
      .req_frame_count     (req_frame_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_found_timestamp (rsp_found_timestamp),
      .rsp_found_position  (rsp_found_position),
      .rsp_found_frames    (rsp_found_frames),
      .rsp_entries_held    (rsp_entries_held),
      .end_of_test         (end_of_test),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped at the cycle limit with %0d responses outstanding", outstanding);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [DATA_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DATA_W-1:0] payload_value();
      int unsigned roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return '0;
      if (roll == 1) return ALL_ONES;
      return wide_random();
   endfunction

   function automatic logic [DATA_W-1:0] edge_stamp();
      if ($urandom_range(0, 1) == 0) return 64'($urandom_range(0, 3));
      return ALL_ONES - $urandom_range(0, 3);
   endfunction

   task automatic send_beat(input logic func, input logic [DATA_W-1:0] stamp,
                            input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] frames);
      req_valid         <= 1'b1;
      req_func          <= func;
      req_timestamp     <= stamp;
      req_file_position <= pos;
      req_frame_count   <= frames;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (func == FN_RECORD) begin
         records_sent++;
         stamp_pool.push_back(stamp);
      end
   endtask

   task automatic pick_random_beat(output logic func, output logic [DATA_W-1:0] stamp,
                                   output logic [DATA_W-1:0] pos,
                                   output logic [DATA_W-1:0] frames);
      int unsigned       roll;
      logic [DATA_W-1:0] known;
      known  = '0;
      if (stamp_pool.size() != 0)
         known = stamp_pool[$urandom_range(0, stamp_pool.size() - 1)];
      func   = ($urandom_range(0, 1) == 0) ? FN_RECORD : FN_FIND;
      pos    = payload_value();
      frames = payload_value();
      roll   = $urandom_range(0, 99);
      if (func == FN_RECORD) begin
         if (roll < 20)
            stamp = known;
         else if (roll < 60)
            stamp = wide_random();
         else if (roll < 85)
            stamp = CLUSTER_BASE + $urandom_range(0, 3000);
         else
            stamp = edge_stamp();
      end else begin
         if (roll < 25)
            stamp = known;
         else if (roll < 50)
            stamp = ($urandom_range(0, 1) == 0) ? known + 1 : known - 1;
         else if (roll < 75)
            stamp = wide_random();
         else if (roll < 90)
            stamp = CLUSTER_BASE + $urandom_range(0, 3000);
         else
            stamp = edge_stamp();
      end
   endtask

   // hold the receiver off long enough for the block to back up its input
   initial begin
      wait (beats_sent >= HOLD_OFF_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : receiver
      rx_style_type style;
      int unsigned  span;
      int unsigned  tick;
      tick = 0;
      forever begin
         style = rx_style_type'($urandom_range(0, 3));
         span  = $urandom_range(8, 120);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (style)
               RX_OPEN:   rsp_ready <= !hold_off;
               RX_MOSTLY: rsp_ready <= !hold_off && ($urandom_range(0, 3) != 0);
               RX_DUTY:   rsp_ready <= !hold_off && ((tick % 5) < 2);
               default:   rsp_ready <= !hold_off && ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic              func;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] pos;
      logic [DATA_W-1:0] frames;
      int unsigned       burst;
      int unsigned       random_sent;
      random_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_beat(FN_FIND,   '0,             '0,           '0);
      send_beat(FN_FIND,   ALL_ONES,       '0,           '0);
      send_beat(FN_RECORD, 64'd1000,       ALL_ONES,     '0);
      send_beat(FN_FIND,   64'd5,          '0,           '0);
      send_beat(FN_FIND,   64'd1000,       '0,           '0);
      send_beat(FN_FIND,   ALL_ONES,       '0,           '0);
      send_beat(FN_RECORD, '0,             '0,           ALL_ONES);
      send_beat(FN_RECORD, ALL_ONES,       {32{2'b01}},  {32{2'b10}});
      send_beat(FN_RECORD, 64'd1000,       64'd7,        64'd7);
      send_beat(FN_FIND,   64'd999,        ALL_ONES,     ALL_ONES);
      send_beat(FN_FIND,   64'd1001,       '0,           '0);
      send_beat(FN_FIND,   ALL_ONES,       '0,           '0);
      send_beat(FN_FIND,   ALL_ONES - 1,   '0,           '0);
      send_beat(FN_FIND,   '0,             '0,           '0);
      send_beat(FN_RECORD, 64'd500,        64'h1234,     64'h42);
      send_beat(FN_RECORD, 64'd2000,       wide_random(), wide_random());
      send_beat(FN_RECORD, ALL_ONES - 1,   wide_random(), wide_random());
      send_beat(FN_FIND,   64'd1500,       '0,           '0);
      send_beat(FN_RECORD, 64'd1,          ALL_ONES,     ALL_ONES);
      send_beat(FN_FIND,   64'd1,          '0,           '0);

      while (random_sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && random_sent < RANDOM_ITEMS) begin
            pick_random_beat(func, stamp, pos, frames);
            send_beat(func, stamp, pos, frames);
            random_sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d beats (%0d record, %0d find): %0d inserted, %0d duplicate, %0d full,",
               beats_sent, records_sent, beats_sent - records_sent,
               u_check.status_tally[ST_INSERTED], u_check.status_tally[ST_DUPLICATE],
               u_check.status_tally[ST_FULL]);
      $display("  %0d found, %0d empty; table peaked at %0d of %0d, one %0d-cycle hold-off",
               u_check.status_tally[ST_FOUND], u_check.status_tally[ST_EMPTY],
               u_check.peak_held, STIT_CAPACITY, HOLD_OFF_CYCLES);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
